// ----- rtl/linear_search_key_value_table_defines.svh -----
// Assertion macros shared by the key/value table RTL.
`ifndef LINEAR_SEARCH_KEY_VALUE_TABLE_DEFINES_SVH
`define LINEAR_SEARCH_KEY_VALUE_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define KV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define KV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define KV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/lskv_pkg.sv -----
// Types and constants of the linear-search key/value table.
package lskv_pkg;

    localparam int unsigned KEY_BITS   = 32;
    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned COUNT_BITS = 5;

    typedef enum logic [1:0] {
        CMD_INSERT         = 2'd0,
        CMD_LOOKUP         = 2'd1,
        CMD_REMOVE         = 2'd2,
        CMD_LOOKUP_DEFAULT = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_e_t;

    // Read address select for the entry memory
    typedef enum logic [1:0] {
        RD_ZERO  = 2'd0,
        RD_NEXT  = 2'd1,
        RD_NEXT2 = 2'd2
    } rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    step;
        logic    mark_hit;
        logic    decide;
        logic    shift_wr;
        logic    shift_done;
        logic    out_load;
    } ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic match;
        logic last_search;
        logic do_shift;
        logic shift_last;
    } sts_t;

    // Result item as held in the output register
    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] value_out;
        status_e_t             status;
        logic [COUNT_BITS-1:0] count;
        logic                  empty_res;
    } res_t;

endpackage

// ----- rtl/lskv_req_if.sv -----
// Request channel: command, key and value with valid/ready.
interface lskv_req_if;
    import lskv_pkg::*;

    logic                        valid;
    logic                        ready;
    cmd_e_t                      command;
    logic        [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

// ----- rtl/lskv_rsp_if.sv -----
// Response channel: one result item per request, valid/ready.
interface lskv_rsp_if;
    import lskv_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         found;
    logic signed [VALUE_BITS-1:0] value_out;
    logic        [1:0]            status;
    logic        [COUNT_BITS-1:0] count;
    logic                         empty_res;

    modport source (output valid, found, value_out, status, count, empty_res, input ready);
    modport sink   (input valid, found, value_out, status, count, empty_res, output ready);
endinterface

// ----- rtl/linear_search_key_value_table.sv -----
// Top level of the linear-search key/value table.
//
// Requests arrive on req (valid/ready): command, key and, for insert, value.
// Each request gives exactly one result item on rsp (valid/ready): found,
// value_out, status, count and empty_res, in request order.
// An item is accepted when valid and ready are both high at a clock edge.
// Each item steps through idle/accept, search, decide and result. The search
// reads the entries from slot 0 and stops at a match or after the last
// valid entry; an empty table skips it. Remove of a present key adds a
// shift-down of the entries above it before the result step.
// The entry memory (one read, one write per cycle) lets the search and the
// shift each step through one entry a cycle.
// One item is in flight at a time; req.ready is high only while idle.
// The output register holds a finished result while the next item is
// accepted and searched; a stalled rsp holds the sequencer at its result step.
// Reset clears the entry count and the handshakes; the entry memory is not
// cleared, entries at or above the count are never read.
`include "linear_search_key_value_table_defines.svh"

module linear_search_key_value_table #(
    parameter int unsigned DEPTH       = 16,
    parameter int unsigned KEY_WIDTH   = 32,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input logic        clk,
    input logic        rst_n,
    lskv_req_if.sink   req,
    lskv_rsp_if.source rsp
);
    import lskv_pkg::*;

    ctl_t ctl;
    sts_t sts;
    res_t res;

    logic req_fire;
    logic rsp_full;
    logic rsp_absent;
    logic rsp_hit;

    lskv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    lskv_dp #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_command (req.command),
        .req_key     (req.key),
        .req_value   (req.value),
        .ctl         (ctl),
        .sts         (sts),
        .res         (res)
    );

    // Result payload
    assign rsp.found     = res.found;
    assign rsp.value_out = res.value_out;
    assign rsp.status    = res.status;
    assign rsp.count     = res.count;
    assign rsp.empty_res = res.empty_res;

    // Terms used by the checks
    assign req_fire   = req.valid && req.ready;
    assign rsp_full   = rsp.valid && (rsp.status == ST_FULL);
    assign rsp_absent = rsp.valid && (rsp.status == ST_ABSENT);
    assign rsp_hit    = rsp.valid && rsp.found;

    // Checks
    `KV_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_fire, !req.ready, "ready after accept")
    `KV_ASSERT_IMPLY(a_full_not_found, clk, rst_n, rsp_full, !rsp.found, "full with hit")
    `KV_ASSERT_IMPLY(a_found_ok, clk, rst_n, rsp_hit, rsp.status == ST_OK, "hit not ok")
    `KV_ASSERT_IMPLY(a_absent_zero, clk, rst_n, rsp_absent, rsp.value_out == '0, "absent nonzero")

endmodule

// ----- rtl/lskv_ctrl.sv -----
// Sequencer for search, update, shift-down and result hand-off.
module lskv_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  lskv_pkg::sts_t sts,
    output lskv_pkg::ctl_t ctl
);
    import lskv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ctl            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    if (sts.empty)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = RD_ZERO;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                priority if (sts.match)
                begin
                    ctl.mark_hit = 1'b1;
                    state_next   = S_DECIDE;
                end
                else if (sts.last_search)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ctl.step   = 1'b1;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_NEXT;
                end
            end
            S_DECIDE:
            begin
                ctl.decide = 1'b1;
                if (sts.do_shift)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_NEXT;
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SHIFT:
            begin
                ctl.shift_wr = 1'b1;
                if (sts.shift_last)
                begin
                    ctl.shift_done = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_NEXT2;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/lskv_dp.sv -----
// Entry memory, request registers, compare and result registers.
module lskv_dp #(
    parameter int unsigned DEPTH       = 16,
    parameter int unsigned KEY_WIDTH   = 32,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lskv_pkg::cmd_e_t                    req_command,
    input  logic        [lskv_pkg::KEY_BITS-1:0]   req_key,
    input  logic signed [lskv_pkg::VALUE_BITS-1:0] req_value,
    input  lskv_pkg::ctl_t                      ctl,
    output lskv_pkg::sts_t                      sts,
    output lskv_pkg::res_t                      res
);
    import lskv_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned NW = CW + 1;
    localparam int unsigned KW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int unsigned VW = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;

    // Entry memory, one write and one registered read per cycle
    logic [KW-1:0] key_mem [DEPTH];
    logic [VW-1:0] val_mem [DEPTH];
    logic [KW-1:0] rd_key_reg;
    logic [VW-1:0] rd_val_reg;

    // Request and working registers
    cmd_e_t        cmd_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] val_reg;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] count_reg;
    logic          hit_reg;
    logic [VW-1:0] res_val_reg;
    status_e_t     res_status_reg;
    res_t          out_reg;

    logic [NW-1:0] idx1, idx2, count_ext;
    logic [AW-1:0] rd_addr;
    logic          full, append_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_key;
    logic [VW-1:0] wr_val;

    assign idx1      = NW'(idx_reg) + NW'(1);
    assign idx2      = NW'(idx_reg) + NW'(2);
    assign count_ext = NW'(count_reg);
    assign full      = (count_reg == CW'(DEPTH));
    assign append_ok = !hit_reg && !full;

    // Status toward the controller
    assign sts.empty       = (count_reg == '0);
    assign sts.match       = (rd_key_reg == key_reg);
    assign sts.last_search = (idx1 >= count_ext);
    assign sts.do_shift    = (cmd_reg == CMD_REMOVE) && hit_reg && (idx1 < count_ext);
    assign sts.shift_last  = (idx2 >= count_ext);

    assign res = out_reg;

    // Read address
    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_ZERO:  rd_addr = '0;
            RD_NEXT:  rd_addr = idx1[AW-1:0];
            RD_NEXT2: rd_addr = idx2[AW-1:0];
            default:  rd_addr = '0;
        endcase
    end

    // Write port: update, append or shift down one place
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_key  = key_reg;
        wr_val  = val_reg;
        if (ctl.shift_wr)
        begin
            wr_en  = 1'b1;
            wr_key = rd_key_reg;
            wr_val = rd_val_reg;
        end
        else if (ctl.decide)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                if (hit_reg)
                begin
                    wr_en = 1'b1;
                end
                else if (!full)
                begin
                    wr_en   = 1'b1;
                    wr_addr = count_reg[AW-1:0];
                end
            end
            else if (cmd_reg == CMD_LOOKUP_DEFAULT && append_ok)
            begin
                wr_en   = 1'b1;
                wr_addr = count_reg[AW-1:0];
                wr_val  = '0;
            end
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.shift_done)
        begin
            count_reg <= count_reg - CW'(1);
        end
        else if (ctl.decide)
        begin
            if ((cmd_reg == CMD_INSERT || cmd_reg == CMD_LOOKUP_DEFAULT) && append_ok)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd_reg == CMD_REMOVE && hit_reg && !(idx1 < count_ext))
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Request, index and hit
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= req_command;
            key_reg <= KW'(req_key);
            val_reg <= VW'(req_value);
            idx_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (ctl.step || ctl.shift_wr)
            begin
                idx_reg <= idx1[AW-1:0];
            end
            if (ctl.mark_hit)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // Result fields, settled at the decide step
    always_ff @(posedge clk)
    begin
        if (ctl.decide)
        begin
            res_val_reg    <= '0;
            res_status_reg <= ST_OK;
            unique case (cmd_reg)
                CMD_INSERT:
                begin
                    if (hit_reg || !full)
                        res_val_reg <= val_reg;
                    else
                        res_status_reg <= ST_FULL;
                end
                CMD_LOOKUP:
                begin
                    if (hit_reg)
                        res_val_reg <= rd_val_reg;
                    else
                        res_status_reg <= ST_ABSENT;
                end
                CMD_REMOVE:
                begin
                    if (!hit_reg)
                        res_status_reg <= ST_ABSENT;
                end
                CMD_LOOKUP_DEFAULT:
                begin
                    if (hit_reg)
                        res_val_reg <= rd_val_reg;
                    else if (full)
                        res_status_reg <= ST_FULL;
                end
                default:
                begin
                    res_status_reg <= ST_OK;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_reg.found     <= hit_reg;
            out_reg.value_out <= VALUE_BITS'(res_val_reg);
            out_reg.status    <= res_status_reg;
            out_reg.count     <= COUNT_BITS'(count_reg);
            out_reg.empty_res <= (count_reg == '0);
        end
    end

endmodule
